@@ design/tpa_pkg.sv @@
package tpa_pkg;

    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int GAIN_WIDTH_DEF  = 16;
    localparam int SUM_WIDTH_DEF   = 32;

    localparam int AXES            = 3;
    localparam int OUT_WIDTH       = 11;
    localparam int LIMIT_WIDTH     = 10;
    localparam int OUT_SHIFT       = 14;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_KP        = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_KI        = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_KD        = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WIND_HIGH = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WIND_LOW  = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SEP       = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LIMIT     = 3'd6;

    localparam int WIND_HIGH_RST = 12800;
    localparam int WIND_LOW_RST  = -12800;
    localparam int SEP_RST       = 12800;
    localparam int LIMIT_RST     = 200;

    typedef logic signed [OUT_WIDTH-1:0] drive_t;

    typedef struct packed {
        logic accept;
        logic advance;
    } lane_ctrl_t;

endpackage

@@ design/tpa_cfg.sv @@
module tpa_cfg #(
    parameter int ANGLE_WIDTH = tpa_pkg::ANGLE_WIDTH_DEF,
    parameter int GAIN_WIDTH  = tpa_pkg::GAIN_WIDTH_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write,
    input  logic [tpa_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
    input  logic [3*GAIN_WIDTH-1:0]                  cfg_data,
    output logic [3*GAIN_WIDTH-1:0]                  kp,
    output logic [3*GAIN_WIDTH-1:0]                  ki,
    output logic [3*GAIN_WIDTH-1:0]                  kd,
    output logic signed [ANGLE_WIDTH-1:0]            windup_high,
    output logic signed [ANGLE_WIDTH-1:0]            windup_low,
    output logic [ANGLE_WIDTH-1:0]                   sep_threshold,
    output logic [tpa_pkg::LIMIT_WIDTH-1:0]          output_limit
);

    localparam int ANGLE_MAX = (1 << (ANGLE_WIDTH - 1)) - 1;
    localparam int ANGLE_MIN = -ANGLE_MAX - 1;
    localparam int UMAX      = (1 << ANGLE_WIDTH) - 1;
    localparam int WH_INIT   = (tpa_pkg::WIND_HIGH_RST > ANGLE_MAX) ?
                               ANGLE_MAX : tpa_pkg::WIND_HIGH_RST;
    localparam int WL_INIT   = (tpa_pkg::WIND_LOW_RST < ANGLE_MIN) ?
                               ANGLE_MIN : tpa_pkg::WIND_LOW_RST;
    localparam int SEP_INIT  = (tpa_pkg::SEP_RST > UMAX) ? UMAX : tpa_pkg::SEP_RST;

    logic [3*GAIN_WIDTH-1:0]              kp_reg;
    logic [3*GAIN_WIDTH-1:0]              ki_reg;
    logic [3*GAIN_WIDTH-1:0]              kd_reg;
    logic signed [ANGLE_WIDTH-1:0]        windup_high_reg;
    logic signed [ANGLE_WIDTH-1:0]        windup_low_reg;
    logic [ANGLE_WIDTH-1:0]               sep_reg;
    logic [tpa_pkg::LIMIT_WIDTH-1:0]      limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg          <= '0;
            ki_reg          <= '0;
            kd_reg          <= '0;
            windup_high_reg <= ANGLE_WIDTH'(WH_INIT);
            windup_low_reg  <= ANGLE_WIDTH'(WL_INIT);
            sep_reg         <= ANGLE_WIDTH'(SEP_INIT);
            limit_reg       <= tpa_pkg::LIMIT_WIDTH'(tpa_pkg::LIMIT_RST);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tpa_pkg::REG_KP:        kp_reg          <= cfg_data;
                tpa_pkg::REG_KI:        ki_reg          <= cfg_data;
                tpa_pkg::REG_KD:        kd_reg          <= cfg_data;
                tpa_pkg::REG_WIND_HIGH: windup_high_reg <= cfg_data[ANGLE_WIDTH-1:0];
                tpa_pkg::REG_WIND_LOW:  windup_low_reg  <= cfg_data[ANGLE_WIDTH-1:0];
                tpa_pkg::REG_SEP:       sep_reg         <= cfg_data[ANGLE_WIDTH-1:0];
                tpa_pkg::REG_LIMIT:     limit_reg       <= cfg_data[tpa_pkg::LIMIT_WIDTH-1:0];
                default:                ;
            endcase
        end
    end

    assign kp            = kp_reg;
    assign ki            = ki_reg;
    assign kd            = kd_reg;
    assign windup_high   = windup_high_reg;
    assign windup_low    = windup_low_reg;
    assign sep_threshold = sep_reg;
    assign output_limit  = limit_reg;

endmodule

@@ design/tpa_lane.sv @@
module tpa_lane #(
    parameter int ANGLE_WIDTH = tpa_pkg::ANGLE_WIDTH_DEF,
    parameter int GAIN_WIDTH  = tpa_pkg::GAIN_WIDTH_DEF,
    parameter int SUM_WIDTH   = tpa_pkg::SUM_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tpa_pkg::lane_ctrl_t               ctrl,
    input  logic signed [ANGLE_WIDTH-1:0]     target,
    input  logic signed [ANGLE_WIDTH-1:0]     measured,
    input  logic [GAIN_WIDTH-1:0]             kp,
    input  logic [GAIN_WIDTH-1:0]             ki,
    input  logic [GAIN_WIDTH-1:0]             kd,
    input  logic signed [ANGLE_WIDTH-1:0]     windup_high,
    input  logic signed [ANGLE_WIDTH-1:0]     windup_low,
    input  logic [ANGLE_WIDTH-1:0]            sep_threshold,
    input  logic [tpa_pkg::LIMIT_WIDTH-1:0]   output_limit,
    output tpa_pkg::drive_t                   drive
);

    localparam int EW  = ANGLE_WIDTH + 1;
    localparam int DW  = ANGLE_WIDTH + 2;
    localparam int SW  = ((SUM_WIDTH > EW) ? SUM_WIDTH : EW) + 1;
    localparam int PW  = GAIN_WIDTH + 1 + EW;
    localparam int DPW = GAIN_WIDTH + 1 + DW;
    localparam int IPW = GAIN_WIDTH + 1 + SUM_WIDTH;
    localparam int TW  = ((DPW > IPW) ? DPW : IPW) + 2;

    localparam logic signed [SW-1:0] SUM_MAX = $signed(SW'({1'b0, {(SUM_WIDTH-1){1'b1}}}));
    localparam logic signed [SW-1:0] SUM_MIN = ~SUM_MAX;

    logic signed [EW-1:0]         err;
    logic [EW-1:0]                mag;
    logic                         gate;
    logic                         accumulate;
    logic signed [SW-1:0]         sum_wide;
    logic signed [SUM_WIDTH-1:0]  error_sum_next;
    logic signed [SUM_WIDTH-1:0]  error_sum_reg;
    logic signed [EW-1:0]         previous_error_reg;
    logic signed [DW-1:0]         diff;

    logic signed [DW-1:0]         diff_s1_reg;
    logic                         gate_s1_reg;

    logic signed [PW-1:0]         p_next;
    logic signed [PW-1:0]         p_reg;
    logic signed [DPW-1:0]        d_next;
    logic signed [DPW-1:0]        d_reg;
    logic signed [IPW-1:0]        i_next;
    logic signed [IPW-1:0]        i_reg;

    logic signed [TW-1:0]         total;
    logic signed [TW-1:0]         shifted;
    logic signed [TW-1:0]         lim;
    logic signed [TW-1:0]         neg_lim;

    // error, separation gate, anti-windup decision, saturating accumulate, error difference
    always_comb
    begin
        err  = EW'(target) - EW'(measured);
        mag  = err[EW-1] ? $unsigned(-err) : $unsigned(err);
        gate = (mag <= {1'b0, sep_threshold});
        if (!gate)
            accumulate = 1'b0;
        else if (measured > windup_high)
            accumulate = err[EW-1];
        else if (measured < windup_low)
            accumulate = !err[EW-1] && (err != '0);
        else
            accumulate = 1'b1;

        sum_wide = SW'(error_sum_reg) + SW'(err);
        if (!accumulate)
            error_sum_next = error_sum_reg;
        else if (sum_wide > SUM_MAX)
            error_sum_next = SUM_MAX[SUM_WIDTH-1:0];
        else if (sum_wide < SUM_MIN)
            error_sum_next = SUM_MIN[SUM_WIDTH-1:0];
        else
            error_sum_next = sum_wide[SUM_WIDTH-1:0];

        diff = DW'(err) - DW'(previous_error_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg      <= '0;
            previous_error_reg <= '0;
        end
        else if (ctrl.accept)
        begin
            error_sum_reg      <= error_sum_next;
            previous_error_reg <= err;
        end
    end

    // state registers hold the values left by the item sitting in stage 1
    always_comb
    begin
        p_next = PW'($signed({1'b0, kp})) * PW'(previous_error_reg);
        d_next = DPW'($signed({1'b0, kd})) * DPW'(diff_s1_reg);
        if (gate_s1_reg)
            i_next = IPW'($signed({1'b0, ki})) * IPW'(error_sum_reg);
        else
            i_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            diff_s1_reg <= diff;
            gate_s1_reg <= gate;
        end
        if (ctrl.advance)
        begin
            p_reg <= p_next;
            d_reg <= d_next;
            i_reg <= i_next;
        end
    end

    always_comb
    begin
        total   = TW'(p_reg) + TW'(d_reg) + TW'(i_reg);
        shifted = total >>> tpa_pkg::OUT_SHIFT;
        lim     = TW'($signed({1'b0, output_limit}));
        neg_lim = -lim;
        if (shifted > lim)
            drive = lim[tpa_pkg::OUT_WIDTH-1:0];
        else if (shifted < neg_lim)
            drive = neg_lim[tpa_pkg::OUT_WIDTH-1:0];
        else
            drive = shifted[tpa_pkg::OUT_WIDTH-1:0];
    end

endmodule

@@ design/tpa_merge.sv @@
module tpa_merge (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  tpa_pkg::drive_t   lane_drive [tpa_pkg::AXES],
    input  logic              out_stall,
    output logic              out_valid,
    output logic              ready,
    output tpa_pkg::drive_t   drive_roll,
    output tpa_pkg::drive_t   drive_pitch,
    output tpa_pkg::drive_t   drive_yaw
);

    logic            out_valid_reg;
    logic            out_valid_next;
    tpa_pkg::drive_t drive_reg [tpa_pkg::AXES];

    assign ready          = !out_valid_reg || !out_stall;
    assign out_valid_next = load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            drive_reg <= lane_drive;
    end

    assign out_valid   = out_valid_reg;
    assign drive_roll  = drive_reg[0];
    assign drive_pitch = drive_reg[1];
    assign drive_yaw   = drive_reg[2];

endmodule

@@ design/three_axis_pid_antiwindup_unit.sv @@
// Each item passes state update, multiply and sum/clamp, each step registered, stalls between.
// Throughput: one item per cycle unless stalled; accumulator add/saturate is combinational.
// Each axis runs in its own lane; the output register merges the three drives.
// Reset: async active low; clears error sums, previous errors and pipeline valids,
// gains to 0, windup limits to +-12800, separation threshold 12800, output limit 200.
module three_axis_pid_antiwindup_unit #(
    parameter int ANGLE_WIDTH = tpa_pkg::ANGLE_WIDTH_DEF,
    parameter int GAIN_WIDTH  = tpa_pkg::GAIN_WIDTH_DEF,
    parameter int SUM_WIDTH   = tpa_pkg::SUM_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [tpa_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [3*GAIN_WIDTH-1:0]              cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [ANGLE_WIDTH-1:0]        target_roll,
    input  logic signed [ANGLE_WIDTH-1:0]        target_pitch,
    input  logic signed [ANGLE_WIDTH-1:0]        target_yaw,
    input  logic signed [ANGLE_WIDTH-1:0]        measured_roll,
    input  logic signed [ANGLE_WIDTH-1:0]        measured_pitch,
    input  logic signed [ANGLE_WIDTH-1:0]        measured_yaw,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output tpa_pkg::drive_t                      drive_roll,
    output tpa_pkg::drive_t                      drive_pitch,
    output tpa_pkg::drive_t                      drive_yaw
);

    logic [3*GAIN_WIDTH-1:0]              kp;
    logic [3*GAIN_WIDTH-1:0]              ki;
    logic [3*GAIN_WIDTH-1:0]              kd;
    logic signed [ANGLE_WIDTH-1:0]        windup_high;
    logic signed [ANGLE_WIDTH-1:0]        windup_low;
    logic [ANGLE_WIDTH-1:0]               sep_threshold;
    logic [tpa_pkg::LIMIT_WIDTH-1:0]      output_limit;

    logic signed [ANGLE_WIDTH-1:0]        target   [tpa_pkg::AXES];
    logic signed [ANGLE_WIDTH-1:0]        measured [tpa_pkg::AXES];
    tpa_pkg::drive_t                      lane_drive [tpa_pkg::AXES];

    tpa_pkg::lane_ctrl_t                  lane_ctrl;
    logic                                 s1_valid_reg;
    logic                                 s1_valid_next;
    logic                                 s2_valid_reg;
    logic                                 s2_valid_next;
    logic                                 s1_free;
    logic                                 s2_free;
    logic                                 out_load;
    logic                                 out_ready;

    tpa_cfg #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .GAIN_WIDTH  (GAIN_WIDTH)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .kp            (kp),
        .ki            (ki),
        .kd            (kd),
        .windup_high   (windup_high),
        .windup_low    (windup_low),
        .sep_threshold (sep_threshold),
        .output_limit  (output_limit)
    );

    assign target[0]   = target_roll;
    assign target[1]   = target_pitch;
    assign target[2]   = target_yaw;
    assign measured[0] = measured_roll;
    assign measured[1] = measured_pitch;
    assign measured[2] = measured_yaw;

    // pipeline control: stage 1, stage 2, output register
    always_comb
    begin
        out_load          = s2_valid_reg && out_ready;
        s2_free           = !s2_valid_reg || out_ready;
        lane_ctrl.advance = s1_valid_reg && s2_free;
        s1_free           = !s1_valid_reg || s2_free;
        in_stall          = !s1_free;
        lane_ctrl.accept  = in_valid && s1_free;
        s1_valid_next     = lane_ctrl.accept || (s1_valid_reg && !lane_ctrl.advance);
        s2_valid_next     = lane_ctrl.advance || (s2_valid_reg && !out_load);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    for (genvar l = 0; l < tpa_pkg::AXES; l++)
    begin : g_lane
        tpa_lane #(
            .ANGLE_WIDTH (ANGLE_WIDTH),
            .GAIN_WIDTH  (GAIN_WIDTH),
            .SUM_WIDTH   (SUM_WIDTH)
        ) u_lane (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (lane_ctrl),
            .target        (target[l]),
            .measured      (measured[l]),
            .kp            (kp[l*GAIN_WIDTH +: GAIN_WIDTH]),
            .ki            (ki[l*GAIN_WIDTH +: GAIN_WIDTH]),
            .kd            (kd[l*GAIN_WIDTH +: GAIN_WIDTH]),
            .windup_high   (windup_high),
            .windup_low    (windup_low),
            .sep_threshold (sep_threshold),
            .output_limit  (output_limit),
            .drive         (lane_drive[l])
        );
    end

    tpa_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (out_load),
        .lane_drive  (lane_drive),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .ready       (out_ready),
        .drive_roll  (drive_roll),
        .drive_pitch (drive_pitch),
        .drive_yaw   (drive_yaw)
    );

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && out_valid && out_stall))
        else $error("input stalled with room in the pipeline");

    a_accept_moves_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_ctrl.accept && s1_valid_reg) |-> lane_ctrl.advance)
        else $error("stage 1 overwritten before transfer");

    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !lane_ctrl.advance) |=> s1_valid_reg)
        else $error("stage 1 item dropped");

    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid)
        else $error("result lost at output register");

endmodule
